>>> hdl/qgi_pkg.sv
package qgi_pkg;

   typedef struct packed {
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic        [31:0] step_time;
   } qgi_req_type;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic               skipped;
      logic               fell_to_identity;
   } qgi_rsp_type;

   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_LOAD      = 4'd1,
      OP_DERIV     = 4'd2,
      OP_INCR      = 4'd3,
      OP_SQ        = 4'd4,
      OP_SQRT_INIT = 4'd5,
      OP_SQRT_STEP = 4'd6,
      OP_DIV_INIT  = 4'd7,
      OP_DIV_STEP  = 4'd8,
      OP_DIV_WRITE = 4'd9,
      OP_IDENT     = 4'd10,
      OP_EMIT      = 4'd11
   } qgi_op_type;

   typedef struct packed {
      qgi_op_type op;
      logic [3:0] idx;
   } qgi_cmd_type;

   typedef struct packed {
      logic skip;
      logic small_norm;
      logic out_busy;
   } qgi_status_type;

   localparam int DERIV_LAST = 14;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;

endpackage

>>> hdl/qgi_ctrl.sv
module qgi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output qgi_pkg::qgi_cmd_type    cmd,
   input  qgi_pkg::qgi_status_type status
);

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_BRANCH = 16'h0002,
      S_DERIV  = 16'h0004,
      S_WAIT1  = 16'h0008,
      S_INCR   = 16'h0010,
      S_WAIT2  = 16'h0020,
      S_SQ     = 16'h0040,
      S_WAIT3  = 16'h0080,
      S_SQRTI  = 16'h0100,
      S_SQRT   = 16'h0200,
      S_CHECK  = 16'h0400,
      S_DIVI   = 16'h0800,
      S_DIVS   = 16'h1000,
      S_DIVW   = 16'h2000,
      S_IDENT  = 16'h4000,
      S_EMIT   = 16'h8000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] kidx_ff, kidx_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      kidx_in  = kidx_ff;
      cmd.op   = qgi_pkg::OP_NOP;
      cmd.idx  = 4'd0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = qgi_pkg::OP_LOAD;
               state_in = S_BRANCH;
            end
         end
         S_BRANCH: begin
            cnt_in   = 5'd0;
            state_in = status.skip ? S_EMIT : S_DERIV;
         end
         S_DERIV: begin
            cmd.op  = qgi_pkg::OP_DERIV;
            cmd.idx = cnt_ff[3:0];
            if (cnt_ff[1:0] == 2'd2) begin
               cnt_in = {1'b0, cnt_ff[3:2] + 2'd1, 2'd0};
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
            if (cnt_ff[3:0] == 4'(qgi_pkg::DERIV_LAST)) begin
               state_in = S_WAIT1;
            end
         end
         S_WAIT1: begin
            cnt_in   = 5'd0;
            state_in = S_INCR;
         end
         S_INCR: begin
            cmd.op  = qgi_pkg::OP_INCR;
            cmd.idx = {2'd0, cnt_ff[1:0]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = S_WAIT2;
            end
         end
         S_WAIT2: begin
            cnt_in   = 5'd0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op  = qgi_pkg::OP_SQ;
            cmd.idx = {2'd0, cnt_ff[1:0]};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = S_WAIT3;
            end
         end
         S_WAIT3: begin
            state_in = S_SQRTI;
         end
         S_SQRTI: begin
            cmd.op   = qgi_pkg::OP_SQRT_INIT;
            cnt_in   = 5'd0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = qgi_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(qgi_pkg::SQRT_STEPS - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            kidx_in  = 2'd0;
            state_in = status.small_norm ? S_IDENT : S_DIVI;
         end
         S_DIVI: begin
            cmd.op   = qgi_pkg::OP_DIV_INIT;
            cmd.idx  = {2'd0, kidx_ff};
            cnt_in   = 5'd0;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.op = qgi_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(qgi_pkg::DIV_STEPS - 1)) begin
               state_in = S_DIVW;
            end
         end
         S_DIVW: begin
            cmd.op  = qgi_pkg::OP_DIV_WRITE;
            cmd.idx = {2'd0, kidx_ff};
            kidx_in = kidx_ff + 2'd1;
            state_in = (kidx_ff == 2'd3) ? S_EMIT : S_DIVI;
         end
         S_IDENT: begin
            cmd.op   = qgi_pkg::OP_IDENT;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.op   = qgi_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
         kidx_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         kidx_ff  <= kidx_in;
      end
   end

endmodule

>>> hdl/qgi_dp.sv
module qgi_dp #(
   parameter int QUAT_FRAC_BITS = 30,
   parameter int RATE_FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  qgi_pkg::qgi_cmd_type    cmd,
   input  qgi_pkg::qgi_req_type    req_payload,
   output qgi_pkg::qgi_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output qgi_pkg::qgi_rsp_type    rsp_payload
);

   localparam logic [63:0] NORM_MIN_W =
      ((64'd1 << QUAT_FRAC_BITS) + 64'd99999999) / 64'd100000000;
   localparam logic [31:0] NORM_MIN  = NORM_MIN_W[31:0];
   localparam logic [31:0] QUAT_ONE  = 32'd1 << QUAT_FRAC_BITS;

   function automatic logic [4:0] deriv_sel(input logic [3:0] idx);
      logic [4:0] r;
      case (idx)
         4'd0:    r = 5'b01_00_1;
         4'd1:    r = 5'b10_01_1;
         4'd2:    r = 5'b11_10_1;
         4'd4:    r = 5'b00_00_0;
         4'd5:    r = 5'b10_10_0;
         4'd6:    r = 5'b11_01_1;
         4'd8:    r = 5'b00_01_0;
         4'd9:    r = 5'b01_10_1;
         4'd10:   r = 5'b11_00_0;
         4'd12:   r = 5'b00_10_0;
         4'd13:   r = 5'b01_01_0;
         4'd14:   r = 5'b10_00_1;
         default: r = 5'b00_00_0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic signed [31:0] rate_ff [3];
   logic        [31:0] dt_ff;
   logic signed [31:0] q_ff [4];
   logic signed [31:0] d_ff [4];
   logic signed [65:0] acc_ff;
   logic signed [65:0] prod_ff;
   qgi_pkg::qgi_op_type tag_op_ff;
   logic        [3:0]  tag_idx_ff;
   logic        [63:0] v_ff;
   logic        [35:0] rem_ff;
   logic        [31:0] root_ff;
   logic        [31:0] dr_ff;
   logic        [30:0] dlow_ff;
   logic        [30:0] qt_ff;
   logic               ovf_ff;
   logic               neg_ff;
   logic               skip_ff;
   logic               fell_ff;
   logic               rsp_valid_ff;
   qgi_pkg::qgi_rsp_type rsp_ff;

   logic        [4:0]  sel1;
   logic        [4:0]  sel2;
   logic signed [31:0] rate_pick;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   logic signed [65:0] term;
   logic signed [65:0] base;
   logic signed [65:0] dsum;
   logic signed [65:0] isum;
   logic        [35:0] rem2;
   logic        [35:0] trial;
   logic        [31:0] dmag;
   logic        [63:0] dnum;
   logic        [63:0] dlim;
   logic        [32:0] rtry;
   logic               rge;
   logic signed [31:0] div_res;

   assign sel1 = deriv_sel(cmd.idx);
   assign sel2 = deriv_sel(tag_idx_ff);

   always_comb begin
      case (sel1[2:1])
         2'd0:    rate_pick = rate_ff[0];
         2'd1:    rate_pick = rate_ff[1];
         default: rate_pick = rate_ff[2];
      endcase
   end

   always_comb begin
      case (cmd.op)
         qgi_pkg::OP_DERIV: begin
            mul_a = {q_ff[sel1[4:3]][31], q_ff[sel1[4:3]]};
            mul_b = {rate_pick[31], rate_pick};
         end
         qgi_pkg::OP_INCR: begin
            mul_a = {d_ff[cmd.idx[1:0]][31], d_ff[cmd.idx[1:0]]};
            mul_b = {1'b0, dt_ff};
         end
         qgi_pkg::OP_SQ: begin
            mul_a = {1'b0, mag32(q_ff[cmd.idx[1:0]])};
            mul_b = {1'b0, mag32(q_ff[cmd.idx[1:0]])};
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign term = prod_ff >>> RATE_FRAC_BITS;
   assign base = (tag_idx_ff[1:0] == 2'd0) ? 66'sd0 : acc_ff;
   assign dsum = sel2[0] ? (base - term) : (base + term);
   assign isum = (prod_ff >>> 33) + 66'(q_ff[tag_idx_ff[1:0]]);

   assign rem2  = {rem_ff[33:0], v_ff[63:62]};
   assign trial = {2'd0, root_ff, 2'b01};

   assign dmag = mag32(q_ff[cmd.idx[1:0]]);
   assign dnum = 64'(dmag) << QUAT_FRAC_BITS;
   assign dlim = 64'(root_ff) << 31;

   assign rtry = {dr_ff, dlow_ff[30]};
   assign rge  = (rtry >= {1'b0, root_ff});

   always_comb begin
      if (ovf_ff) begin
         div_res = neg_ff ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff) begin
         div_res = -$signed({1'b0, qt_ff});
      end else begin
         div_res = $signed({1'b0, qt_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff[0]      <= QUAT_ONE;
         q_ff[1]      <= 32'sd0;
         q_ff[2]      <= 32'sd0;
         q_ff[3]      <= 32'sd0;
         tag_op_ff    <= qgi_pkg::OP_NOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_ff    <= mul_p;
         tag_op_ff  <= cmd.op;
         tag_idx_ff <= cmd.idx;

         case (tag_op_ff)
            qgi_pkg::OP_DERIV: begin
               acc_ff <= dsum;
               if (tag_idx_ff[1:0] == 2'd2) begin
                  d_ff[tag_idx_ff[3:2]] <= sat32(dsum);
               end
            end
            qgi_pkg::OP_INCR: begin
               q_ff[tag_idx_ff[1:0]] <= sat32(isum);
            end
            qgi_pkg::OP_SQ: begin
               acc_ff <= base + prod_ff;
            end
            default: begin
            end
         endcase

         case (cmd.op)
            qgi_pkg::OP_LOAD: begin
               rate_ff[0] <= req_payload.rate_x;
               rate_ff[1] <= req_payload.rate_y;
               rate_ff[2] <= req_payload.rate_z;
               dt_ff      <= req_payload.step_time;
               skip_ff    <= (req_payload.step_time == 32'd0);
               fell_ff    <= 1'b0;
            end
            qgi_pkg::OP_SQRT_INIT: begin
               v_ff    <= (acc_ff[65:64] != 2'd0) ? {64{1'b1}} : acc_ff[63:0];
               rem_ff  <= 36'd0;
               root_ff <= 32'd0;
            end
            qgi_pkg::OP_SQRT_STEP: begin
               v_ff <= {v_ff[61:0], 2'b00};
               if (rem2 >= trial) begin
                  rem_ff  <= rem2 - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff  <= rem2;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
            end
            qgi_pkg::OP_DIV_INIT: begin
               neg_ff  <= q_ff[cmd.idx[1:0]][31];
               ovf_ff  <= (dnum >= dlim);
               dr_ff   <= dnum[62:31];
               dlow_ff <= dnum[30:0];
               qt_ff   <= 31'd0;
            end
            qgi_pkg::OP_DIV_STEP: begin
               dlow_ff <= {dlow_ff[29:0], 1'b0};
               qt_ff   <= {qt_ff[29:0], rge};
               dr_ff   <= rge ? 32'(rtry - {1'b0, root_ff}) : rtry[31:0];
            end
            qgi_pkg::OP_DIV_WRITE: begin
               q_ff[cmd.idx[1:0]] <= div_res;
            end
            qgi_pkg::OP_IDENT: begin
               q_ff[0] <= QUAT_ONE;
               q_ff[1] <= 32'sd0;
               q_ff[2] <= 32'sd0;
               q_ff[3] <= 32'sd0;
               fell_ff <= 1'b1;
            end
            qgi_pkg::OP_EMIT: begin
               rsp_ff.quat_w           <= q_ff[0];
               rsp_ff.quat_x           <= q_ff[1];
               rsp_ff.quat_y           <= q_ff[2];
               rsp_ff.quat_z           <= q_ff[3];
               rsp_ff.skipped          <= skip_ff;
               rsp_ff.fell_to_identity <= fell_ff;
            end
            default: begin
            end
         endcase

         if (cmd.op == qgi_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.skip       = skip_ff;
   assign status.small_norm = (root_ff < NORM_MIN);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.skipped && rsp_ff.fell_to_identity))
      else $error("skipped and fell_to_identity both set");

   a_fell_is_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fell_to_identity) |->
         (rsp_ff.quat_w == QUAT_ONE && rsp_ff.quat_x == 32'sd0 &&
          rsp_ff.quat_y == 32'sd0 && rsp_ff.quat_z == 32'sd0))
      else $error("fallback result is not identity");

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op) == qgi_pkg::OP_EMIT)
      else $error("result raised without emit command");

   a_no_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == qgi_pkg::OP_EMIT) |-> !(rsp_valid_ff && rsp_stall))
      else $error("emit while output slot is stalled");

endmodule

>>> hdl/quaternion_gyro_integrator.sv
// Quaternion gyro integrator: keeps an attitude quaternion (Q2.30) and
// advances it by one first-order step per item, then renormalizes.
// Input channel req_*: three body rates (Q8.24 rad/s) and a step time
// (unsigned Q0.32 s); an item is taken when req_valid is high and
// req_stall is low. Result channel rsp_*: the new quaternion plus the
// skipped and fell_to_identity flags, exactly one result per item.
// One item at a time runs through a shared 33x33 multiplier, a 32-step
// bit-serial square root and a 31-step divider used once per component.
// A zero step time leaves the quaternion unchanged; when the norm is too
// small the state falls to identity. One item is processed at a time:
// req_stall stays high from acceptance until the result is loaded into
// the output register.
// The output register lets the next item be taken while a result waits;
// if rsp_stall holds the slot, the next result waits before the emit
// step until the slot drains.
// Synchronous reset sets the quaternion to identity and empties the
// output register.
module quaternion_gyro_integrator #(
   parameter int QUAT_FRAC_BITS = 30,
   parameter int RATE_FRAC_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qgi_pkg::qgi_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output qgi_pkg::qgi_rsp_type rsp_payload
);

   qgi_pkg::qgi_cmd_type    cmd;
   qgi_pkg::qgi_status_type status;

   qgi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   qgi_dp #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
      .RATE_FRAC_BITS (RATE_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
